@@ rtl/pps_pkg.sv @@
package pps_pkg;

    localparam int SLOT_W  = 4;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int TIME_W  = 20;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 5;

    localparam int SLOT_COUNT = 1 << SLOT_W;

    localparam logic [TIME_W-1:0] TIME_MAX  = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [SUM_W-1:0]  sum_t;

endpackage

@@ rtl/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler, one tick per item. A load item (opcode 0)
// writes one task slot; loads to slots at or beyond MAX_TASKS are dropped.
// A tick item (opcode 1) walks the first min(task_count, MAX_TASKS, 16) slots
// of the task table with a single priority comparator, one slot per cycle;
// then three steps decrement the chosen task, form turnaround and waiting
// time, and update the saturating totals. When the run is already done or no
// slot is in play the walk is skipped. A tick's result sits in an output
// register; loads are taken while it waits, and a following tick holds in
// its last step until the result goes. The user must write task_count through
// cfg_we/cfg_wdata only while no item is in flight; the block does not enforce this.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [SLOT_W-1:0]  s_task_slot,
    input  logic [ARR_W-1:0]   s_arrival_time,
    input  logic [BURST_W-1:0] s_burst_length,
    input  logic [PRIO_W-1:0]  s_priority_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SLOT_W-1:0]  m_running_task,
    output logic               m_idle,
    output logic               m_task_finished,
    output logic [TIME_W-1:0]  m_turnaround,
    output logic [TIME_W-1:0]  m_waiting,
    output logic [SUM_W-1:0]   m_total_turnaround,
    output logic [SUM_W-1:0]   m_total_waiting,
    output logic               m_all_done,
    output logic [TIME_W-1:0]  m_tick_time
);

    // only slots reachable by task_slot can ever hold work
    localparam int DEPTH = (MAX_TASKS < SLOT_COUNT) ? MAX_TASKS : SLOT_COUNT;
    localparam int IW    = $clog2(DEPTH);
    localparam int NW    = IW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_TAT  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;

    logic [ARR_W-1:0]   arr_mem   [DEPTH];
    logic [BURST_W-1:0] burst_mem [DEPTH];
    logic [PRIO_W-1:0]  prio_mem  [DEPTH];
    logic [BURST_W-1:0] rem_mem   [DEPTH];

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [2:0]       state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    lim_reg, lim_next;
    time_t            t_reg, t_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    pick_reg, pick_next;
    logic [PRIO_W-1:0] best_reg, best_next;
    logic             fin_reg, fin_next;
    time_t            tat_reg, tat_next;
    time_t            wt_reg, wt_next;
    time_t            time_reg, time_next;
    logic [CNT_W-1:0] fcount_reg, fcount_next;
    sum_t             sum_tat_reg, sum_tat_next;
    sum_t             sum_wt_reg, sum_wt_next;
    logic [CNT_W-1:0] task_count_reg, task_count_next;

    logic             m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0] out_task_reg, out_task_next;
    logic             out_idle_reg, out_idle_next;
    logic             out_fin_reg, out_fin_next;
    time_t            out_tat_reg, out_tat_next;
    time_t            out_wt_reg, out_wt_next;
    sum_t             out_stat_reg, out_stat_next;
    sum_t             out_swt_reg, out_swt_next;
    logic             out_done_reg, out_done_next;
    time_t            out_time_reg, out_time_next;

    logic               load_en;
    logic               dec_en;
    logic [ARR_W-1:0]   rd_arr;
    logic [BURST_W-1:0] rd_burst;
    logic [PRIO_W-1:0]  rd_prio;
    logic [BURST_W-1:0] rd_rem;
    logic [BURST_W-1:0] rem_dec;
    logic               cand;
    logic               scan_last;
    logic [NW-1:0]      lim_calc;
    logic [TIME_W:0]    tat_diff;
    logic [TIME_W:0]    time_inc;
    logic [SUM_W:0]     stat_sum;
    logic [SUM_W:0]     swt_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign load_en = s_valid && s_ready && (s_opcode == OP_LOAD)
                     && (int'(s_task_slot) < DEPTH);
    assign dec_en  = (state_reg == ST_TAT) && found_reg;

    // unwritten slots read as zero
    assign rd_arr   = valid_reg[idx_reg] ? arr_mem[idx_reg]   : '0;
    assign rd_burst = valid_reg[idx_reg] ? burst_mem[idx_reg] : '0;
    assign rd_prio  = valid_reg[idx_reg] ? prio_mem[idx_reg]  : '0;
    assign rd_rem   = valid_reg[idx_reg] ? rem_mem[idx_reg]   : '0;
    assign rem_dec  = rd_rem - 1'b1;

    assign cand = (rd_rem != '0) && (TIME_W'(rd_arr) <= t_reg)
                  && (!found_reg || (rd_prio < best_reg));
    assign scan_last = ((NW'(idx_reg) + NW'(1)) == lim_reg);
    assign lim_calc  = (int'(task_count_reg) < DEPTH) ? NW'(task_count_reg) : NW'(DEPTH);

    assign tat_diff = (TIME_W+1)'(t_reg) + (TIME_W+1)'(1) - (TIME_W+1)'(rd_arr);
    assign time_inc = (TIME_W+1)'(time_reg) + (TIME_W+1)'(1);
    assign stat_sum = (SUM_W+1)'(sum_tat_reg) + (SUM_W+1)'(tat_reg);
    assign swt_sum  = (SUM_W+1)'(sum_wt_reg) + (SUM_W+1)'(wt_reg);

    always_comb begin
        valid_next      = valid_reg;
        state_next      = state_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        t_next          = t_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        fin_next        = fin_reg;
        tat_next        = tat_reg;
        wt_next         = wt_reg;
        time_next       = time_reg;
        fcount_next     = fcount_reg;
        sum_tat_next    = sum_tat_reg;
        sum_wt_next     = sum_wt_reg;
        task_count_next = cfg_we ? cfg_wdata : task_count_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_task_next   = out_task_reg;
        out_idle_next   = out_idle_reg;
        out_fin_next    = out_fin_reg;
        out_tat_next    = out_tat_reg;
        out_wt_next     = out_wt_reg;
        out_stat_next   = out_stat_reg;
        out_swt_next    = out_swt_reg;
        out_done_next   = out_done_reg;
        out_time_next   = out_time_reg;

        if (load_en) begin
            valid_next[s_task_slot[IW-1:0]] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_opcode == OP_TICK) begin
                    t_next     = time_reg;
                    found_next = 1'b0;
                    pick_next  = '0;
                    best_next  = '0;
                    fin_next   = 1'b0;
                    tat_next   = '0;
                    wt_next    = '0;
                    idx_next   = '0;
                    lim_next   = lim_calc;
                    // skip the walk once the run is done or nothing is in play
                    if (fcount_reg < task_count_reg && lim_calc != '0) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_TAT;
                    end
                end
            end
            ST_SCAN: begin
                if (cand) begin
                    found_next = 1'b1;
                    pick_next  = idx_reg;
                    best_next  = rd_prio;
                end
                if (scan_last) begin
                    // point the read port at the winner for the update steps
                    idx_next   = cand ? idx_reg : pick_reg;
                    state_next = ST_TAT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TAT: begin
                if (found_reg && rem_dec == '0) begin
                    fin_next = 1'b1;
                    tat_next = (tat_diff > (TIME_W+1)'(TIME_MAX)) ? TIME_MAX
                                                                 : tat_diff[TIME_W-1:0];
                end
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (fin_reg) begin
                    wt_next      = (tat_reg >= TIME_W'(rd_burst))
                                   ? tat_reg - TIME_W'(rd_burst) : '0;
                    sum_tat_next = stat_sum[SUM_W] ? SUM_MAX : stat_sum[SUM_W-1:0];
                    fcount_next  = (fcount_reg == COUNT_MAX) ? COUNT_MAX
                                                             : fcount_reg + 1'b1;
                end
                state_next = ST_SUM;
            end
            ST_SUM: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    sum_wt_next   = swt_sum[SUM_W] ? SUM_MAX : swt_sum[SUM_W-1:0];
                    time_next     = time_inc[TIME_W] ? TIME_MAX : time_inc[TIME_W-1:0];
                    m_valid_next  = 1'b1;
                    out_task_next = found_reg ? SLOT_W'(pick_reg) : '0;
                    out_idle_next = !found_reg;
                    out_fin_next  = fin_reg;
                    out_tat_next  = tat_reg;
                    out_wt_next   = wt_reg;
                    out_stat_next = sum_tat_reg;
                    out_swt_next  = swt_sum[SUM_W] ? SUM_MAX : swt_sum[SUM_W-1:0];
                    out_done_next = (fcount_reg >= task_count_reg);
                    out_time_next = t_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            arr_mem[s_task_slot[IW-1:0]]   <= s_arrival_time;
            burst_mem[s_task_slot[IW-1:0]] <= s_burst_length;
            prio_mem[s_task_slot[IW-1:0]]  <= s_priority_level;
            rem_mem[s_task_slot[IW-1:0]]   <= s_burst_length;
        end else if (dec_en) begin
            rem_mem[idx_reg] <= rem_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            fcount_reg     <= '0;
            sum_tat_reg    <= '0;
            sum_wt_reg     <= '0;
            task_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            state_reg      <= state_next;
            time_reg       <= time_next;
            fcount_reg     <= fcount_next;
            sum_tat_reg    <= sum_tat_next;
            sum_wt_reg     <= sum_wt_next;
            task_count_reg <= task_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        lim_reg      <= lim_next;
        t_reg        <= t_next;
        found_reg    <= found_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        fin_reg      <= fin_next;
        tat_reg      <= tat_next;
        wt_reg       <= wt_next;
        out_task_reg <= out_task_next;
        out_idle_reg <= out_idle_next;
        out_fin_reg  <= out_fin_next;
        out_tat_reg  <= out_tat_next;
        out_wt_reg   <= out_wt_next;
        out_stat_reg <= out_stat_next;
        out_swt_reg  <= out_swt_next;
        out_done_reg <= out_done_next;
        out_time_reg <= out_time_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_running_task     = out_task_reg;
    assign m_idle             = out_idle_reg;
    assign m_task_finished    = out_fin_reg;
    assign m_turnaround       = out_tat_reg;
    assign m_waiting          = out_wt_reg;
    assign m_total_turnaround = out_stat_reg;
    assign m_total_waiting    = out_swt_reg;
    assign m_all_done         = out_done_reg;
    assign m_tick_time        = out_time_reg;

endmodule

@@ rtl/pps_checker.sv @@
module pps_checker
    import pps_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [SLOT_W-1:0]  m_running_task,
    input logic               m_idle,
    input logic               m_task_finished,
    input logic [TIME_W-1:0]  m_turnaround,
    input logic [TIME_W-1:0]  m_waiting,
    input logic [SUM_W-1:0]   m_total_turnaround,
    input logic [SUM_W-1:0]   m_total_waiting,
    input logic [TIME_W-1:0]  m_tick_time
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tick_time)
            && $stable(m_running_task) && $stable(m_total_turnaround))
        else $error("result changed while stalled");

    a_idle_no_task: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_idle |-> m_running_task == '0 && !m_task_finished)
        else $error("idle tick reports a task");

    a_unfinished_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_task_finished |-> m_turnaround == '0 && m_waiting == '0)
        else $error("times reported without completion");

    a_wait_le_tat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_waiting <= m_turnaround
            && m_total_waiting <= m_total_turnaround)
        else $error("waiting exceeds turnaround");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
